### hw/rtl/cel_pkg.sv
// Shared types and constants of the CSR element lookup block.
package cel_pkg;

	// Input item kinds.
	localparam logic [1:0] KIND_ROW_START = 2'd0;
	localparam logic [1:0] KIND_COL_INDEX = 2'd1;
	localparam logic [1:0] KIND_QUERY     = 2'd2;

	// Reset value of the not-found position register.
	localparam logic [15:0] NF_RESET = 16'hFFFF;

	// Depth of the command queue between the front and back ends.
	localparam int CMD_DEPTH = 2;
	localparam int CMD_PW    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

	// One input request.
	typedef struct packed {
		logic [1:0]  kind;
		logic [12:0] write_position;
		logic [15:0] write_value;
		logic [9:0]  query_row;
		logic [15:0] query_col;
		logic        final_query;
	} cel_item_t;

	// One result.
	typedef struct packed {
		logic        found;
		logic [15:0] position;
		logic        final_result;
	} cel_result_t;

	// Classified operation handed to the back end.
	typedef enum logic [1:0] {
		OP_ROW_WR,
		OP_COL_WR,
		OP_QUERY,
		OP_MISS
	} cel_op_t;

	// Command carried through the queue.
	typedef struct packed {
		cel_op_t     op;
		logic [12:0] addr;
		logic [15:0] data;
		logic        last;
	} cel_cmd_t;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH_END,
		ST_LOAD_END,
		ST_SEARCH,
		ST_DONE
	} cel_state_t;

endpackage

### hw/rtl/cel_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cel_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data register holds between reads.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/cel_front.sv
// Front end: accepts input requests, range-checks and classifies them.
module cel_front #(
	parameter int MAX_ROWS    = 1024,
	parameter int MAX_ENTRIES = 4096
) (
	input  logic              push,
	input  cel_pkg::cel_item_t item,
	input  logic              q_full,
	output logic              full,
	output logic              q_push,
	output cel_pkg::cel_cmd_t cmd
);

	import cel_pkg::*;

	logic accept;
	logic keep;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_push = accept && keep;

	// Classify the request; ignored writes and unused kinds never reach the queue.
	always_comb begin
		keep     = 1'b0;
		cmd.op   = OP_MISS;
		cmd.addr = item.write_position;
		cmd.data = item.write_value;
		cmd.last = item.final_query;
		unique case (item.kind)
			KIND_ROW_START: begin
				cmd.op = OP_ROW_WR;
				keep   = 32'(item.write_position) <= 32'(MAX_ROWS);
			end
			KIND_COL_INDEX: begin
				cmd.op = OP_COL_WR;
				keep   = 32'(item.write_position) < 32'(MAX_ENTRIES);
			end
			KIND_QUERY: begin
				keep     = 1'b1;
				cmd.addr = 13'(item.query_row);
				cmd.data = item.query_col;
				cmd.op   = (32'(item.query_row) < 32'(MAX_ROWS)) ? OP_QUERY : OP_MISS;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

endmodule

### hw/rtl/cel_cmd_fifo.sv
// Short command queue between the front end and the back end.
module cel_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cel_pkg::cel_cmd_t wdata,
	input  logic              pop,
	output cel_pkg::cel_cmd_t rdata,
	output logic              full,
	output logic              valid
);

	import cel_pkg::*;

	cel_cmd_t            slot_q [CMD_DEPTH];
	logic [CMD_PW-1:0]   wr_ptr_q;
	logic [CMD_PW-1:0]   rd_ptr_q;
	logic [CMD_CW-1:0]   count_q;

	assign full  = count_q == CMD_CW'(CMD_DEPTH);
	assign valid = count_q != '0;
	assign rdata = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMD_PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMD_PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### hw/rtl/cel_back.sv
// Back end: table writes and the binary search sequencer with its result register.
module cel_back #(
	parameter int MAX_ROWS     = 1024,
	parameter int MAX_ENTRIES  = 4096,
	parameter int COLUMN_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  cel_pkg::cel_cmd_t    cmd,
	output logic                 cmd_pop,
	input  logic [15:0]          nf_index,
	input  logic                 res_pop,
	output logic                 res_valid,
	output cel_pkg::cel_result_t result
);

	import cel_pkg::*;

	localparam int RPW = $clog2(MAX_ENTRIES + 1);
	localparam int RAW = $clog2(MAX_ROWS + 1);
	localparam int CAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	cel_state_t state_q, state_n;

	logic [RAW-1:0]          addr_q;
	logic [COLUMN_WIDTH-1:0] col_q;
	logic                    last_q;
	logic [RPW-1:0]          lo_q, hi_q, end_q, mid_q;
	logic                    hit_q;
	logic                    res_valid_q;
	cel_result_t             res_q;

	logic                    row_we, row_re, col_we, col_re;
	logic [RAW-1:0]          row_waddr, row_raddr;
	logic [RPW-1:0]          row_wdata, row_rdata;
	logic [CAW-1:0]          col_waddr, col_raddr;
	logic [COLUMN_WIDTH-1:0] col_wdata, col_rdata;
	logic [31:0]             wval32, sat32;

	logic                    less;
	logic [RPW-1:0]          lo_n, hi_n, srch_lo, srch_hi, mid_n;
	logic [RPW:0]            mid_sum;
	logic                    cont;
	logic                    res_free;
	logic                    res_load;

	// Row start offsets.
	cel_ram #(.WIDTH(RPW), .DEPTH(MAX_ROWS + 1), .AW(RAW)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	// Column indices.
	cel_ram #(.WIDTH(COLUMN_WIDTH), .DEPTH(MAX_ENTRIES), .AW(CAW)) u_col_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (col_waddr),
		.wdata (col_wdata),
		.re    (col_re),
		.raddr (col_raddr),
		.rdata (col_rdata)
	);

	// Write data: row starts saturate at the entry count, columns keep their low bits.
	assign wval32    = 32'(cmd.data);
	assign sat32     = (wval32 > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : wval32;
	assign row_waddr = RAW'(cmd.addr);
	assign row_wdata = RPW'(sat32);
	assign col_waddr = CAW'(cmd.addr);
	assign col_wdata = COLUMN_WIDTH'(cmd.data);

	// One search step: narrow the segment around the column just read.
	assign less = col_rdata < col_q;
	assign lo_n = less ? RPW'(mid_q + RPW'(1)) : lo_q;
	assign hi_n = less ? hi_q : mid_q;

	// The first step starts from the fetched segment, later ones from the step above.
	assign srch_lo = (state_q == ST_LOAD_END) ? lo_q : lo_n;
	assign srch_hi = (state_q == ST_LOAD_END) ? row_rdata : hi_n;
	assign cont    = srch_lo < srch_hi;
	assign mid_sum = {1'b0, srch_lo} + {1'b0, srch_hi};
	assign mid_n   = mid_sum[RPW:1];

	assign res_free = !res_valid_q || res_pop;

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == OP_QUERY) begin
						state_n = ST_FETCH_END;
					end else if (cmd.op == OP_MISS) begin
						state_n = ST_DONE;
					end
				end
			end
			ST_FETCH_END: state_n = ST_LOAD_END;
			ST_LOAD_END:  state_n = cont ? ST_SEARCH : ST_DONE;
			ST_SEARCH:    state_n = cont ? ST_SEARCH : ST_DONE;
			ST_DONE:      state_n = res_free ? ST_IDLE : ST_DONE;
			default:      state_n = ST_IDLE;
		endcase
	end

	// Memory controls and queue pop.
	always_comb begin
		cmd_pop   = 1'b0;
		row_we    = 1'b0;
		col_we    = 1'b0;
		row_re    = 1'b0;
		col_re    = 1'b0;
		row_raddr = RAW'(cmd.addr);
		col_raddr = CAW'(mid_n);
		res_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					row_we  = cmd.op == OP_ROW_WR;
					col_we  = cmd.op == OP_COL_WR;
					row_re  = cmd.op == OP_QUERY;
				end
			end
			ST_FETCH_END: begin
				row_re    = 1'b1;
				row_raddr = RAW'(addr_q + RAW'(1));
			end
			ST_LOAD_END, ST_SEARCH: begin
				col_re = cont;
			end
			ST_DONE: begin
				res_load = res_free;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Search datapath and result register.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					addr_q <= RAW'(cmd.addr);
					col_q  <= COLUMN_WIDTH'(cmd.data);
					last_q <= cmd.last;
					hit_q  <= 1'b0;
					lo_q   <= '0;
					end_q  <= '0;
				end
			end
			ST_FETCH_END: begin
				lo_q <= row_rdata;
			end
			ST_LOAD_END: begin
				end_q <= row_rdata;
				hi_q  <= row_rdata;
				mid_q <= mid_n;
			end
			ST_SEARCH: begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
				// The entry that last became the upper bound is the final candidate.
				if (!less) begin
					hit_q <= col_rdata == col_q;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					res_q.found        <= hit_q && (lo_q < end_q);
					res_q.position     <= (hit_q && (lo_q < end_q)) ? 16'(lo_q) : nf_index;
					res_q.final_result <= last_q;
				end
			end
			default: begin
				hit_q <= 1'b0;
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign result    = res_q;

endmodule

### hw/rtl/csr_element_lookup.sv
// Top level of the CSR element lookup block.
//
//   channel   handshake                  payload
//   item      push / full                cel_item_t: kind, write, query fields
//   result    empty / pop                cel_result_t: found, position, final_result
//   cfg       cfg_valid / cfg_ready      cfg_data: not-found position
//
// A write request reaches its table as the back end pops it; a lookup ends with its search
// steps (about log2 of the row's length plus one), one column RAM read each.
// With a single read port, the row-start RAM gives a lookup its row's start, then its end.
// Reset clears control state and the not-found position; the tables hold nothing valid until written.
// A two-entry queue lets requests enter while a lookup runs; a waiting result stalls
// the back end only when the next result is ready to replace it.
module csr_element_lookup #(
	parameter int MAX_ROWS     = 1024,
	parameter int MAX_ENTRIES  = 4096,
	parameter int COLUMN_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  cel_pkg::cel_item_t   item,
	output logic                 empty,
	input  logic                 pop,
	output cel_pkg::cel_result_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [15:0]          cfg_data
);

	import cel_pkg::*;

	logic [15:0] nf_q;
	logic        q_full, q_push, q_valid, cmd_pop;
	cel_cmd_t    front_cmd, q_cmd;
	logic        res_valid;
	logic        res_pop;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_q <= NF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			nf_q <= cfg_data;
		end
	end

	// Front end.
	cel_front #(.MAX_ROWS(MAX_ROWS), .MAX_ENTRIES(MAX_ENTRIES)) u_front (
		.push   (push),
		.item   (item),
		.q_full (q_full),
		.full   (full),
		.q_push (q_push),
		.cmd    (front_cmd)
	);

	// Command queue.
	cel_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (front_cmd),
		.pop    (cmd_pop),
		.rdata  (q_cmd),
		.full   (q_full),
		.valid  (q_valid)
	);

	// Back end.
	assign res_pop = pop && res_valid;
	assign empty   = !res_valid;

	cel_back #(
		.MAX_ROWS     (MAX_ROWS),
		.MAX_ENTRIES  (MAX_ENTRIES),
		.COLUMN_WIDTH (COLUMN_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (cmd_pop),
		.nf_index  (nf_q),
		.res_pop   (res_pop),
		.res_valid (res_valid),
		.result    (result)
	);

	// The queue is never written while full and never read while empty.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> q_valid) else $error("command queue read while empty");

	// A hit always names an entry inside the column table.
	a_hit_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.found) |-> (32'(result.position) < 32'(MAX_ENTRIES)))
		else $error("hit position beyond the column table");

endmodule
